// ----- src/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/mcdt_pkg.sv -----
`timescale 1ns / 1ps

package mcdt_pkg;

   localparam int CHANNELS_DEFAULT = 16;
   localparam int CHANNEL_W        = 4;
   localparam int TIME_W           = 32;
   localparam int CSR_DATA_W       = 16;
   localparam int CSR_INDEX_W      = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_DELAY = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_POLARITY_MASK  = CSR_INDEX_W'(1);

   localparam logic [CSR_DATA_W-1:0] DELAY_RESET    = CSR_DATA_W'(50);
   localparam logic [CSR_DATA_W-1:0] POLARITY_RESET = '0;

   typedef struct packed {
      logic              cand_level;
      logic [TIME_W-1:0] cand_start;
      logic              acc_level;
      logic [TIME_W-1:0] last_change;
      logic [TIME_W-1:0] last_interval;
   } chan_state_type;

   typedef struct packed {
      chan_state_type state;
      logic           changed;
   } chan_update_type;

endpackage

// ----- src/mcdt_chan_update.sv -----
`timescale 1ns / 1ps

module mcdt_chan_update (
   input  mcdt_pkg::chan_state_type               cur,
   input  logic                                   level,
   input  logic [mcdt_pkg::TIME_W-1:0]            now_ms,
   input  logic [mcdt_pkg::CSR_DATA_W-1:0]        delay_ms,
   output mcdt_pkg::chan_update_type              upd
);

   logic [mcdt_pkg::TIME_W-1:0] elapsed;
   logic                        settled;

   // wrap-safe settle test
   assign elapsed = now_ms - cur.cand_start;
   assign settled = elapsed > mcdt_pkg::TIME_W'(delay_ms);

   always_comb begin
      upd.state   = cur;
      upd.changed = 1'b0;
      priority if (level != cur.cand_level) begin
         upd.state.cand_level = level;
         upd.state.cand_start = now_ms;
      end else if (settled && (level != cur.acc_level)) begin
         upd.state.acc_level     = level;
         upd.state.last_interval = now_ms - cur.last_change;
         upd.state.last_change   = now_ms;
         upd.changed             = 1'b1;
      end
   end

endmodule

// ----- src/multi_channel_debounce_timer.sv -----
`timescale 1ns / 1ps
// Debounces up to sixteen input pins that are polled one at a time.
// Request channel (req_*): one poll of one pin, with the channel index,
// the raw pin level and the current millisecond time.
// Response channel (rsp_*): one response per request, in order, with the
// debounced level, a one-poll change pulse and the last change interval.
// Register channel (csr_*): index 0 sets the debounce delay in ms, index 1
// the per-channel polarity mask; other indexes are ignored. Always ready;
// write only while no request is in flight.
// A request passes from the input register to the response register, and
// a receiver stall can hold it in the input register.
// Throughput: one request per cycle while the receiver does not stall; the
// per-channel state is read and written back in the same cycle, so polls
// of one channel may follow each other back to back.
// When the receiver stalls, the response register holds; the input
// register still takes one more request, then req_ready drops.
// Reset (synchronous) clears all channel state to level 0, time 0,
// delay 50 ms, polarity mask 0, and empties both registers.
// Polls of a channel index at or above CHANNELS give an all-zero response.

`include "assert_macros.svh"

module multi_channel_debounce_timer #(
   parameter int CHANNELS = mcdt_pkg::CHANNELS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mcdt_pkg::CHANNEL_W-1:0]      req_channel,
   input  logic                                req_raw_level,
   input  logic [mcdt_pkg::TIME_W-1:0]         req_now_ms,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_stable_level,
   output logic                                rsp_changed,
   output logic [mcdt_pkg::TIME_W-1:0]         rsp_interval_ms,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mcdt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mcdt_pkg::CSR_DATA_W-1:0]     csr_data
);

   // channel index is four bits wide, so at most sixteen entries are reachable
   localparam int DEPTH = (CHANNELS < (1 << mcdt_pkg::CHANNEL_W)) ?
                          CHANNELS : (1 << mcdt_pkg::CHANNEL_W);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [mcdt_pkg::CSR_DATA_W-1:0] delay_ff;
   logic [mcdt_pkg::CSR_DATA_W-1:0] polarity_ff;

   logic                            s1_valid_ff;
   logic [mcdt_pkg::CHANNEL_W-1:0]  s1_channel_ff;
   logic                            s1_raw_ff;
   logic [mcdt_pkg::TIME_W-1:0]     s1_now_ff;

   logic                            rsp_valid_ff;
   logic                            rsp_stable_ff;
   logic                            rsp_changed_ff;
   logic [mcdt_pkg::TIME_W-1:0]     rsp_interval_ff;

   mcdt_pkg::chan_state_type        state_ff [DEPTH];

   logic                            advance;
   logic                            in_range;
   logic [IDX_W-1:0]                idx;
   logic                            level;
   mcdt_pkg::chan_state_type        cur;
   mcdt_pkg::chan_update_type       upd;

   // register port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= mcdt_pkg::DELAY_RESET;
         polarity_ff <= mcdt_pkg::POLARITY_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            mcdt_pkg::REG_DEBOUNCE_DELAY: delay_ff    <= csr_data;
            mcdt_pkg::REG_POLARITY_MASK:  polarity_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // handshake
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_channel_ff <= req_channel;
         s1_raw_ff     <= req_raw_level;
         s1_now_ff     <= req_now_ms;
      end
   end

   // channel update
   assign in_range = 32'(s1_channel_ff) < CHANNELS;
   assign idx      = s1_channel_ff[IDX_W-1:0];
   assign level    = s1_raw_ff ^ polarity_ff[s1_channel_ff];
   assign cur      = state_ff[idx];

   mcdt_chan_update u_update (
      .cur      (cur),
      .level    (level),
      .now_ms   (s1_now_ff),
      .delay_ms (delay_ff),
      .upd      (upd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            state_ff[i] <= '0;
         end
      end else if (advance && in_range) begin
         state_ff[idx] <= upd.state;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_stable_ff   <= in_range && upd.state.acc_level;
         rsp_changed_ff  <= in_range && upd.changed;
         rsp_interval_ff <= in_range ? upd.state.last_interval : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_stable_level = rsp_stable_ff;
   assign rsp_changed      = rsp_changed_ff;
   assign rsp_interval_ms  = rsp_interval_ff;

   `ASSERT_CLK(a_out_of_range_zero, clock, reset,
      (advance && !in_range) |=>
         (!rsp_stable_ff && !rsp_changed_ff && (rsp_interval_ff == '0)),
      "out of range poll gave a non-zero response")

   `ASSERT_CLK(a_change_flips_level, clock, reset,
      (advance && in_range && upd.changed) |=>
         (state_ff[$past(idx)].acc_level != $past(cur.acc_level)),
      "change pulse without a flip of the stable level")

   `ASSERT_CLK(a_change_needs_candidate, clock, reset,
      (advance && upd.changed) |-> (level == cur.cand_level),
      "change accepted on the poll that restarts the timer")

   `ASSERT_CLK(a_stalled_input_holds, clock, reset,
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_channel_ff) && $stable(s1_now_ff)),
      "input register lost a stalled request")

   `ASSERT_ALWAYS(a_reset_empties, clock,
      reset |=> (!s1_valid_ff && !rsp_valid_ff),
      "registers not empty after reset")

endmodule
